### rtl/core/fdp_pkg.sv
// Shared types, constants, DES tables and bit-permutation functions for the domain permutation.
package fdp_pkg;

	localparam int MAX_ROUNDS = 4;
	localparam int KEY_BYTES  = 8;
	localparam int ROUND_W    = $clog2(MAX_ROUNDS + 1);
	localparam int KEY_REGS   = 4;
	localparam int KEY_IDX_W  = 2;
	localparam int DOMAIN_W   = 32;
	localparam int RADIX_W    = 17;
	localparam int WALK_W     = 34;
	localparam int DES_W      = 64;
	localparam int DIV_CNT_W  = 7;
	localparam int CFG_ADDR_W = 6;
	localparam int CFG_DATA_W = 64;

	localparam logic [2:0] REG_DOMAIN_SIZE = 3'd0;
	localparam logic [2:0] REG_RADIX_A     = 3'd1;
	localparam logic [2:0] REG_RADIX_B     = 3'd2;
	localparam logic [2:0] REG_ROUND_COUNT = 3'd3;
	localparam logic [2:0] REG_ROUND_KEY_0 = 3'd4;
	localparam logic [2:0] REG_ROUND_KEY_1 = 3'd5;
	localparam logic [2:0] REG_ROUND_KEY_2 = 3'd6;
	localparam logic [2:0] REG_ROUND_KEY_3 = 3'd7;

	typedef enum logic [1:0] {
		DIV_SPLIT = 2'd0,
		DIV_FUNC  = 2'd1,
		DIV_HALF  = 2'd2
	} div_mode_t;

	typedef struct packed {
		logic [DOMAIN_W-1:0]           domain_size;
		logic [RADIX_W-1:0]            radix_a;
		logic [RADIX_W-1:0]            radix_b;
		logic [2:0]                    round_count;
		logic [KEY_REGS-1:0][DES_W-1:0] round_key;
	} fdp_cfg_t;

	typedef struct packed {
		logic      load;
		logic      set_oor;
		logic      div_start;
		div_mode_t div_mode;
		logic      split_cap;
		logic      des_start;
		logic      f_cap;
		logic      y_cap;
		logic      x_cap;
		logic      comb;
		logic      mul_step;
		logic      recombine;
		logic      out_load;
	} fdp_cmd_t;

	typedef struct packed {
		logic des_done;
		logic div_done;
		logic c_below;
		logic last_round;
		logic no_rounds;
	} fdp_status_t;

	localparam logic [15:0] SHIFT_ONE = 16'b1000_0001_0000_0011;

	localparam int T_IP [64] = '{58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
		62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,57,49,41,33,25,17,9,1,
		59,51,43,35,27,19,11,3,61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
	localparam int T_FP [64] = '{40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
		38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,36,4,44,12,52,20,60,28,
		35,3,43,11,51,19,59,27,34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
	localparam int T_E [48] = '{32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,
		14,15,16,17,16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,
		30,31,32,1};
	localparam int T_P [32] = '{16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
		2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
	localparam int T_PC1 [56] = '{57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,
		59,51,43,35,27,19,11,3,60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,
		30,22,14,6,61,53,45,37,29,21,13,5,28,20,12,4};
	localparam int T_PC2 [48] = '{14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,
		26,8,16,7,27,20,13,2,41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,
		34,53,46,42,50,36,29,32};

	localparam int SBOX [8][64] = '{
		'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
		  4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
		'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
		  0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
		'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
		  13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
		'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
		  10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
		'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
		  4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
		'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
		  9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
		'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
		  1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
		'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
		  7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}
	};

	// positions count from 1 at the MSB
	function automatic logic [63:0] des_ip(input logic [63:0] x);
		logic [63:0] r;
		for (int j = 0; j < 64; j++) r[63-j] = x[64-T_IP[j]];
		return r;
	endfunction

	function automatic logic [63:0] des_fp(input logic [63:0] x);
		logic [63:0] r;
		for (int j = 0; j < 64; j++) r[63-j] = x[64-T_FP[j]];
		return r;
	endfunction

	function automatic logic [55:0] des_pc1(input logic [63:0] x);
		logic [55:0] r;
		for (int j = 0; j < 56; j++) r[55-j] = x[64-T_PC1[j]];
		return r;
	endfunction

	function automatic logic [47:0] des_pc2(input logic [55:0] x);
		logic [47:0] r;
		for (int j = 0; j < 48; j++) r[47-j] = x[56-T_PC2[j]];
		return r;
	endfunction

	function automatic logic [47:0] des_e(input logic [31:0] x);
		logic [47:0] r;
		for (int j = 0; j < 48; j++) r[47-j] = x[32-T_E[j]];
		return r;
	endfunction

	function automatic logic [31:0] des_p(input logic [31:0] x);
		logic [31:0] r;
		for (int j = 0; j < 32; j++) r[31-j] = x[32-T_P[j]];
		return r;
	endfunction

	function automatic logic [31:0] des_sbox(input logic [47:0] x);
		logic [31:0] r;
		logic [5:0]  b6;
		for (int k = 0; k < 8; k++) begin
			b6 = x[47-6*k -: 6];
			r[31-4*k -: 4] = 4'(SBOX[k][{b6[5], b6[0], b6[4:1]}]);
		end
		return r;
	endfunction

	function automatic logic [63:0] byte_swap(input logic [63:0] x);
		logic [63:0] r;
		for (int k = 0; k < 8; k++) r[8*k +: 8] = x[56-8*k +: 8];
		return r;
	endfunction

	function automatic logic [63:0] key_mask();
		logic [63:0] m;
		m = '0;
		for (int k = 0; k < 8; k++) if (k < KEY_BYTES) m[8*k +: 8] = 8'hFF;
		return m;
	endfunction

endpackage

### rtl/core/fdp_in_if.sv
// Input channel: operation and value with valid/ready handshake.
interface fdp_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [31:0] value;

	modport source(output valid, output op, output value, input ready);
	modport sink(input valid, input op, input value, output ready);
endinterface

### rtl/core/fdp_out_if.sv
// Output channel: permuted value and range flag with valid/ready handshake.
interface fdp_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] result;
	logic        out_of_range;

	modport source(output valid, output result, output out_of_range, input ready);
	modport sink(input valid, input result, input out_of_range, output ready);
endinterface

### rtl/core/feistel_domain_permutation.sv
// Top level: keyed mixed-radix Feistel permutation of a configured domain with cycle walking.
// One item at a time. An out-of-range input skips the walk and is passed through unchanged.
// Per round, a walk step runs a DES pass and two bit-serial reductions in the shared divider;
// the walk repeats a data-dependent number of steps.
// A finished result waits in the output register while the next item is taken.
// Reset (arst_n, asynchronous, low) returns config and control to defaults; no clearing pass.
module feistel_domain_permutation import fdp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	fdp_in_if.sink                item_in,
	fdp_out_if.source             item_out,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready
);

	fdp_cfg_t    cfg;
	fdp_cmd_t    cmd;
	fdp_status_t status;
	logic        in_ready, out_valid;

	assign item_in.ready  = in_ready;
	assign item_out.valid = out_valid;

	fdp_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fdp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_in.valid),
		.in_ready  (in_ready),
		.out_ready (item_out.ready),
		.out_valid (out_valid),
		.status    (status),
		.cmd       (cmd)
	);

	fdp_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.status       (status),
		.in_op        (item_in.op),
		.in_value     (item_in.value),
		.result       (item_out.result),
		.out_of_range (item_out.out_of_range)
	);

endmodule

### rtl/core/fdp_cfg_regs.sv
// APB configuration registers: domain size, radices, round count and DES round keys.
module fdp_cfg_regs import fdp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	output fdp_cfg_t              cfg
);

	fdp_cfg_t   cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[CFG_ADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.domain_size <= DOMAIN_W'(1);
			cfg_q.radix_a     <= RADIX_W'(1);
			cfg_q.radix_b     <= RADIX_W'(1);
			cfg_q.round_count <= 3'd4;
			cfg_q.round_key   <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_DOMAIN_SIZE: cfg_q.domain_size <= pwdata[DOMAIN_W-1:0];
				REG_RADIX_A:     cfg_q.radix_a <= pwdata[RADIX_W-1:0];
				REG_RADIX_B:     cfg_q.radix_b <= pwdata[RADIX_W-1:0];
				REG_ROUND_COUNT: cfg_q.round_count <= pwdata[2:0];
				REG_ROUND_KEY_0: cfg_q.round_key[0] <= pwdata;
				REG_ROUND_KEY_1: cfg_q.round_key[1] <= pwdata;
				REG_ROUND_KEY_2: cfg_q.round_key[2] <= pwdata;
				REG_ROUND_KEY_3: cfg_q.round_key[3] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DOMAIN_SIZE: prdata = CFG_DATA_W'(cfg_q.domain_size);
			REG_RADIX_A:     prdata = CFG_DATA_W'(cfg_q.radix_a);
			REG_RADIX_B:     prdata = CFG_DATA_W'(cfg_q.radix_b);
			REG_ROUND_COUNT: prdata = CFG_DATA_W'(cfg_q.round_count);
			REG_ROUND_KEY_0: prdata = cfg_q.round_key[0];
			REG_ROUND_KEY_1: prdata = cfg_q.round_key[1];
			REG_ROUND_KEY_2: prdata = cfg_q.round_key[2];
			REG_ROUND_KEY_3: prdata = cfg_q.round_key[3];
			default:         prdata = '0;
		endcase
	end

endmodule

### rtl/core/fdp_des.sv
// Iterative DES encryption unit, one round per cycle with on-the-fly key schedule.
module fdp_des import fdp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DES_W-1:0] key,
	input  logic [DES_W-1:0] blk,
	output logic             done,
	output logic [DES_W-1:0] result
);

	logic [27:0] c_q, d_q, c_rot, d_rot;
	logic [31:0] l_q, r_q, fx;
	logic [3:0]  cnt_q;
	logic        busy_q, done_q;
	logic [55:0] cd_init;
	logic [63:0] ip_init;

	always_comb begin
		cd_init = des_pc1(key);
		ip_init = des_ip(blk);
		if (SHIFT_ONE[cnt_q]) begin
			c_rot = {c_q[26:0], c_q[27]};
			d_rot = {d_q[26:0], d_q[27]};
		end else begin
			c_rot = {c_q[25:0], c_q[27:26]};
			d_rot = {d_q[25:0], d_q[27:26]};
		end
		fx = des_p(des_sbox(des_e(r_q) ^ des_pc2({c_rot, d_rot})));
	end

	assign result = des_fp({r_q, l_q});
	assign done   = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			c_q <= cd_init[55:28];
			d_q <= cd_init[27:0];
			l_q <= ip_init[63:32];
			r_q <= ip_init[31:0];
		end else if (busy_q) begin
			c_q <= c_rot;
			d_q <= d_rot;
			l_q <= r_q;
			r_q <= l_q ^ fx;
		end
	end

endmodule

### rtl/core/fdp_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit or 34-bit dividend by a 17-bit divisor.
module fdp_div import fdp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               short_op,
	input  logic [DES_W-1:0]   dividend,
	input  logic [RADIX_W-1:0] divisor,
	output logic               done,
	output logic [WALK_W-1:0]  quotient,
	output logic [RADIX_W-1:0] remainder
);

	logic [DES_W-1:0]     num_q;
	logic [RADIX_W-1:0]   rem_q, den_q, rem_n;
	logic [WALK_W-1:0]    quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q, done_q, ge;
	logic [RADIX_W:0]     trial;

	always_comb begin
		trial = {rem_q, num_q[DES_W-1]};
		ge    = trial >= {1'b0, den_q};
		rem_n = ge ? RADIX_W'(trial - {1'b0, den_q}) : trial[RADIX_W-1:0];
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= short_op ? DIV_CNT_W'(WALK_W) : DIV_CNT_W'(DES_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= short_op ? {dividend[WALK_W-1:0], (DES_W-WALK_W)'(0)} : dividend;
			rem_q <= '0;
			quo_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[DES_W-2:0], 1'b0};
			rem_q <= rem_n;
			quo_q <= {quo_q[WALK_W-2:0], ge};
		end
	end

endmodule

### rtl/core/fdp_datapath.sv
// Datapath: walk value, Feistel halves, modular add/sub, recombine multiply, DES and divider units.
module fdp_datapath import fdp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  fdp_cfg_t            cfg,
	input  fdp_cmd_t            cmd,
	output fdp_status_t         status,
	input  logic                in_op,
	input  logic [DOMAIN_W-1:0] in_value,
	output logic [DOMAIN_W-1:0] result,
	output logic                out_of_range
);

	logic                op_q, oor_q, oor_out_q;
	logic [DOMAIN_W-1:0] value_q, result_q;
	logic [WALK_W-1:0]   c_q, l_q, r_q, prod_q;
	logic [RADIX_W-1:0]  a_q, b_q, x_q, y_q;
	logic [ROUND_W-1:0]  rounds_q, k_q, idx;
	logic [DES_W-1:0]    f_q;

	logic [RADIX_W-1:0]  md, t_fwd, t_inv, t_new;
	logic [RADIX_W:0]    sum;
	logic [WALK_W-1:0]   half_fn, other, mul_hi, add_lo;
	logic [DES_W-1:0]    des_key, des_blk, des_res;
	logic [DES_W-1:0]    div_num;
	logic [RADIX_W-1:0]  div_den, div_rem;
	logic [WALK_W-1:0]   div_quo;
	logic                div_short, sel_l;
	logic [RADIX_W+WALK_W-1:0] prod_full;
	logic [WALK_W:0]     join_sum;

	always_comb begin
		idx     = op_q ? ROUND_W'(rounds_q - ROUND_W'(1) - k_q) : k_q;
		md      = idx[0] ? b_q : a_q;
		half_fn = op_q ? l_q : r_q;
		other   = op_q ? r_q : l_q;
		des_key = byte_swap(cfg.round_key[idx[KEY_IDX_W-1:0]] & key_mask());
		des_blk = byte_swap({(DES_W-WALK_W)'(0), half_fn});

		case (cmd.div_mode)
			DIV_FUNC: begin
				div_num   = f_q;
				div_den   = md;
				div_short = 1'b0;
			end
			DIV_HALF: begin
				div_num   = {(DES_W-WALK_W)'(0), other};
				div_den   = md;
				div_short = 1'b1;
			end
			default: begin
				div_num   = {(DES_W-WALK_W)'(0), c_q};
				div_den   = a_q;
				div_short = 1'b1;
			end
		endcase

		sum   = {1'b0, x_q} + {1'b0, y_q};
		t_fwd = (sum >= {1'b0, md}) ? RADIX_W'(sum - {1'b0, md}) : sum[RADIX_W-1:0];
		t_inv = (x_q >= y_q) ? RADIX_W'(x_q - y_q)
		                     : RADIX_W'(({1'b0, x_q} + {1'b0, md}) - {1'b0, y_q});
		t_new = op_q ? t_inv : t_fwd;

		sel_l     = !op_q && rounds_q[0];
		mul_hi    = sel_l ? l_q : r_q;
		add_lo    = sel_l ? r_q : l_q;
		prod_full = a_q * mul_hi;
		join_sum  = {1'b0, prod_q} + {1'b0, add_lo};
	end

	assign status.c_below    = c_q < {(WALK_W-DOMAIN_W)'(0), cfg.domain_size};
	assign status.last_round = ROUND_W'(k_q + ROUND_W'(1)) == rounds_q;
	assign status.no_rounds  = rounds_q == '0;
	assign result            = result_q;
	assign out_of_range      = oor_out_q;

	fdp_des u_des (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.des_start),
		.key    (des_key),
		.blk    (des_blk),
		.done   (status.des_done),
		.result (des_res)
	);

	fdp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.short_op  (div_short),
		.dividend  (div_num),
		.divisor   (div_den),
		.done      (status.div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= in_op;
			value_q <= in_value;
			c_q     <= {(WALK_W-DOMAIN_W)'(0), in_value};
			oor_q   <= 1'b0;
			a_q     <= (cfg.radix_a == '0) ? RADIX_W'(1) : cfg.radix_a;
			b_q     <= (cfg.radix_b == '0) ? RADIX_W'(1) : cfg.radix_b;
			rounds_q <= (32'(cfg.round_count) > MAX_ROUNDS) ? ROUND_W'(MAX_ROUNDS)
			                                               : ROUND_W'(cfg.round_count);
		end
		if (cmd.set_oor) oor_q <= 1'b1;
		if (cmd.split_cap) begin
			k_q <= '0;
			if (op_q && rounds_q[0]) begin
				r_q <= {(WALK_W-RADIX_W)'(0), div_rem};
				l_q <= div_quo;
			end else begin
				l_q <= {(WALK_W-RADIX_W)'(0), div_rem};
				r_q <= div_quo;
			end
		end
		if (cmd.f_cap) f_q <= byte_swap(des_res);
		if (cmd.y_cap) y_q <= div_rem;
		if (cmd.x_cap) x_q <= div_rem;
		if (cmd.comb) begin
			k_q <= ROUND_W'(k_q + ROUND_W'(1));
			if (op_q) begin
				r_q <= l_q;
				l_q <= {(WALK_W-RADIX_W)'(0), t_new};
			end else begin
				l_q <= r_q;
				r_q <= {(WALK_W-RADIX_W)'(0), t_new};
			end
		end
		if (cmd.mul_step) prod_q <= prod_full[WALK_W-1:0];
		if (cmd.recombine) c_q <= join_sum[WALK_W-1:0];
		if (cmd.out_load) begin
			result_q  <= oor_q ? value_q : c_q[DOMAIN_W-1:0];
			oor_out_q <= oor_q;
		end
	end

endmodule

### rtl/core/fdp_ctrl.sv
// Controller: sequences split, DES, reductions, rounds, recombine and cycle walking; owns handshakes.
module fdp_ctrl import fdp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        out_ready,
	output logic        out_valid,
	input  fdp_status_t status,
	output fdp_cmd_t    cmd
);

	typedef enum logic [14:0] {
		ST_IDLE   = 15'b000000000000001,
		ST_CHECK  = 15'b000000000000010,
		ST_SPLIT  = 15'b000000000000100,
		ST_SPLITW = 15'b000000000001000,
		ST_DES    = 15'b000000000010000,
		ST_DESW   = 15'b000000000100000,
		ST_MODF   = 15'b000000001000000,
		ST_MODFW  = 15'b000000010000000,
		ST_MODH   = 15'b000000100000000,
		ST_MODHW  = 15'b000001000000000,
		ST_COMB   = 15'b000010000000000,
		ST_MUL    = 15'b000100000000000,
		ST_JOIN   = 15'b001000000000000,
		ST_TEST   = 15'b010000000000000,
		ST_DONE   = 15'b100000000000000
	} state_t;

	state_t state_q, state_n;
	logic   out_valid_q;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		state_n = state_q;
		cmd     = '0;
		cmd.div_mode = DIV_SPLIT;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.c_below) state_n = ST_SPLIT;
				else begin
					cmd.set_oor = 1'b1;
					state_n     = ST_DONE;
				end
			end
			ST_SPLIT: begin
				cmd.div_start = 1'b1;
				state_n       = ST_SPLITW;
			end
			ST_SPLITW: begin
				if (status.div_done) begin
					cmd.split_cap = 1'b1;
					state_n       = status.no_rounds ? ST_MUL : ST_DES;
				end
			end
			ST_DES: begin
				cmd.des_start = 1'b1;
				state_n       = ST_DESW;
			end
			ST_DESW: begin
				if (status.des_done) begin
					cmd.f_cap = 1'b1;
					state_n   = ST_MODF;
				end
			end
			ST_MODF: begin
				cmd.div_mode  = DIV_FUNC;
				cmd.div_start = 1'b1;
				state_n       = ST_MODFW;
			end
			ST_MODFW: begin
				if (status.div_done) begin
					cmd.y_cap = 1'b1;
					state_n   = ST_MODH;
				end
			end
			ST_MODH: begin
				cmd.div_mode  = DIV_HALF;
				cmd.div_start = 1'b1;
				state_n       = ST_MODHW;
			end
			ST_MODHW: begin
				if (status.div_done) begin
					cmd.x_cap = 1'b1;
					state_n   = ST_COMB;
				end
			end
			ST_COMB: begin
				cmd.comb = 1'b1;
				state_n  = status.last_round ? ST_MUL : ST_DES;
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				state_n      = ST_JOIN;
			end
			ST_JOIN: begin
				cmd.recombine = 1'b1;
				state_n       = ST_TEST;
			end
			ST_TEST: begin
				state_n = status.c_below ? ST_DONE : ST_SPLIT;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

### sim/tb_top.sv
// Self-checking testbench for the Feistel domain permutation: scoreboard, drivers and phases.
`timescale 1ns / 100ps

module tb_top;
	import fdp_pkg::*;

	typedef struct {
		bit [31:0] result;
		bit        out_of_range;
	} perm_res_t;

	class perm_scoreboard;
		bit [63:0]   dom, rad_a, rad_b, rounds;
		bit [63:0]   rkey [4];
		perm_res_t   pending_q [$];
		int unsigned errors, n_in, n_out, n_oor;

		function new();
			dom = 1; rad_a = 1; rad_b = 1; rounds = 4;
			foreach (rkey[k]) rkey[k] = '0;
		endfunction

		function void set_reg(logic [2:0] idx, bit [63:0] v);
			case (idx)
				REG_DOMAIN_SIZE: dom = v[31:0];
				REG_RADIX_A:     rad_a = v[16:0];
				REG_RADIX_B:     rad_b = v[16:0];
				REG_ROUND_COUNT: rounds = v[2:0];
				REG_ROUND_KEY_0: rkey[0] = v;
				REG_ROUND_KEY_1: rkey[1] = v;
				REG_ROUND_KEY_2: rkey[2] = v;
				REG_ROUND_KEY_3: rkey[3] = v;
				default: ;
			endcase
		endfunction

		function bit [63:0] swap64(bit [63:0] x);
			bit [63:0] r;
			for (int k = 0; k < 8; k++) r[8*k +: 8] = x[56-8*k +: 8];
			return r;
		endfunction

		function bit [63:0] des_enc(bit [63:0] key, bit [63:0] blk);
			bit [55:0] cd;
			bit [27:0] c, d;
			bit [47:0] sk [16];
			bit [47:0] ex;
			bit [63:0] ip, pre, res;
			bit [31:0] l, r, t, s, pf;
			bit [5:0]  b6;
			int        sh;
			for (int j = 0; j < 56; j++) cd[55-j] = key[64-T_PC1[j]];
			c = cd[55:28];
			d = cd[27:0];
			for (int i = 0; i < 16; i++) begin
				sh = (i == 0 || i == 1 || i == 8 || i == 15) ? 1 : 2;
				c = (c << sh) | (c >> (28 - sh));
				d = (d << sh) | (d >> (28 - sh));
				cd = {c, d};
				for (int j = 0; j < 48; j++) sk[i][47-j] = cd[56-T_PC2[j]];
			end
			for (int j = 0; j < 64; j++) ip[63-j] = blk[64-T_IP[j]];
			l = ip[63:32];
			r = ip[31:0];
			for (int i = 0; i < 16; i++) begin
				for (int j = 0; j < 48; j++) ex[47-j] = r[32-T_E[j]];
				ex = ex ^ sk[i];
				for (int k = 0; k < 8; k++) begin
					b6 = ex[47-6*k -: 6];
					s[31-4*k -: 4] = 4'(SBOX[k][{b6[5], b6[0], b6[4:1]}]);
				end
				for (int j = 0; j < 32; j++) pf[31-j] = s[32-T_P[j]];
				t = l ^ pf;
				l = r;
				r = t;
			end
			pre = {r, l};
			for (int j = 0; j < 64; j++) res[63-j] = pre[64-T_FP[j]];
			return res;
		endfunction

		function bit [63:0] mix(int i, bit [63:0] half);
			bit [63:0] m;
			m = '0;
			for (int k = 0; k < 8; k++) if (k < KEY_BYTES) m[8*k +: 8] = 8'hFF;
			return swap64(des_enc(swap64(rkey[i & 3] & m), swap64(half)));
		endfunction

		function bit [63:0] step_fwd(bit [63:0] v, bit [63:0] a, bit [63:0] b, int nr);
			bit [63:0] l, r, md, t;
			l = v % a;
			r = v / a;
			for (int i = 0; i < nr; i++) begin
				md = (i & 1) ? b : a;
				t = ((l % md) + (mix(i, r) % md)) % md;
				l = r;
				r = t;
			end
			return (nr & 1) ? a * l + r : a * r + l;
		endfunction

		function bit [63:0] step_inv(bit [63:0] v, bit [63:0] a, bit [63:0] b, int nr);
			bit [63:0] l, r, md, t;
			if (nr & 1) begin
				r = v % a; l = v / a;
			end else begin
				l = v % a; r = v / a;
			end
			for (int i = nr; i > 0; i--) begin
				md = ((i - 1) & 1) ? b : a;
				t = ((r % md) + md - (mix(i - 1, l) % md)) % md;
				r = l;
				l = t;
			end
			return a * r + l;
		endfunction

		function void note_item(bit op, bit [31:0] v);
			perm_res_t e;
			bit [63:0] a, b, cur;
			int        nr;
			n_in++;
			a = (rad_a == 0) ? 1 : rad_a;
			b = (rad_b == 0) ? 1 : rad_b;
			nr = (rounds > MAX_ROUNDS) ? MAX_ROUNDS : int'(rounds);
			if (v >= dom) begin
				e.result = v;
				e.out_of_range = 1'b1;
			end else begin
				cur = v;
				do
					cur = op ? step_inv(cur, a, b, nr) : step_fwd(cur, a, b, nr);
				while (cur >= dom);
				e.result = cur[31:0];
				e.out_of_range = 1'b0;
			end
			pending_q.push_back(e);
		endfunction

		function void check_result(bit [31:0] res, bit oor);
			perm_res_t e;
			n_out++;
			if (oor) n_oor++;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result %h oor %b", $time, res, oor);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (res !== e.result) begin
				$display("%0t: result mismatch exp %h got %h", $time, e.result, res);
				errors++;
			end
			if (oor !== e.out_of_range) begin
				$display("%0t: out_of_range mismatch exp %b got %b", $time,
					e.out_of_range, oor);
				errors++;
			end
		endfunction
	endclass

	localparam int WATCHDOG = 200000;

	logic                  clk;
	logic                  arst_n;
	logic                  psel, penable, pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata, prdata;
	logic                  pready;
	int                    idle_mode;
	int                    quiet;
	perm_scoreboard        sb;

	fdp_in_if  in_if();
	fdp_out_if out_if();

	feistel_domain_permutation uut (
		.clk(clk), .arst_n(arst_n), .item_in(in_if), .item_out(out_if),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		sb = new();
		idle_mode = 0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_if.valid = 1'b0; in_if.op = 1'b0; in_if.value = '0;
		out_if.ready = 1'b0;
	end

	always @(posedge clk) begin
		case (idle_mode)
			2: out_if.ready <= ($urandom % 100) >= 59;
			3: out_if.ready <= ($urandom % 100) >= 36;
			default: out_if.ready <= 1'b1;
		endcase
	end

	always @(posedge clk) begin
		if (in_if.valid && in_if.ready) sb.note_item(in_if.op, in_if.value);
		if (out_if.valid && out_if.ready) sb.check_result(out_if.result, out_if.out_of_range);
	end

	always @(posedge clk) begin
		if (!arst_n || psel || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
			quiet <= 0;
		else if (quiet >= WATCHDOG) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG);
			$display("RESULT: ERROR");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	task automatic reg_write(logic [2:0] idx, bit [63:0] v);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= CFG_ADDR_W'({idx, 3'b000}); pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		sb.set_reg(idx, v);
	endtask

	// wait for an edge first so that a transfer at the current edge is already noted
	task automatic drain();
		@(posedge clk);
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic configure(bit [31:0] d, bit [16:0] a, bit [16:0] b, bit [2:0] nr,
			bit [63:0] k0, bit [63:0] k1, bit [63:0] k2, bit [63:0] k3);
		in_if.valid <= 1'b0;
		drain();
		reg_write(REG_DOMAIN_SIZE, d);
		reg_write(REG_RADIX_A, a);
		reg_write(REG_RADIX_B, b);
		reg_write(REG_ROUND_COUNT, nr);
		reg_write(REG_ROUND_KEY_0, k0);
		reg_write(REG_ROUND_KEY_1, k1);
		reg_write(REG_ROUND_KEY_2, k2);
		reg_write(REG_ROUND_KEY_3, k3);
	endtask

	task automatic send_item(bit op, bit [31:0] v);
		if (idle_mode == 1 || idle_mode == 3) begin
			while (($urandom % 100) < ((idle_mode == 1) ? 59 : 36)) begin
				in_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_if.valid <= 1'b1;
		in_if.op <= op;
		in_if.value <= v;
		do @(posedge clk); while (!in_if.ready);
	endtask

	task automatic random_items(int n, bit [31:0] d);
		bit [31:0] v;
		for (int i = 0; i < n; i++) begin
			idle_mode = (i / 40) % 4;
			if (d == 0)
				v = $urandom;
			else if (d != 32'hFFFFFFFF && ($urandom % 10) == 0)
				v = $urandom_range(32'hFFFFFFFF, d);
			else
				v = $urandom_range(d - 1, 0);
			send_item($urandom % 2, v);
		end
		idle_mode = 0;
	endtask

	function automatic bit [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	initial begin
		#1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults after reset: domain of one, every other value out of range
		send_item(1'b0, 32'd0);
		send_item(1'b1, 32'd0);
		send_item(1'b0, 32'd1);
		send_item(1'b1, 32'hFFFFFFFF);

		// empty domain
		configure(32'd0, 17'd5, 17'd7, 3'd4, '0, '0, '0, '0);
		send_item(1'b0, 32'd0);
		send_item(1'b1, 32'hFFFFFFFF);
		random_items(16, 32'd0);

		// no rounds, zero radices: identity
		configure(32'hFFFFFFFF, 17'd0, 17'd0, 3'd0, '1, '1, '1, '1);
		send_item(1'b0, 32'hFFFFFFFE);
		send_item(1'b1, 32'h55555555);
		send_item(1'b0, 32'hFFFFFFFF);
		random_items(180, 32'hFFFFFFFF);

		// widest radices, walks of several steps
		configure(32'hFFFFFFFF, 17'h1FFFF, 17'h1FFFF, 3'd4, rnd64(), '1, '0, rnd64());
		send_item(1'b0, 32'd0);
		send_item(1'b1, 32'hFFFFFFFE);
		random_items(40, 32'hFFFFFFFF);

		configure(32'hFFFFFFFF, 17'h10000, 17'h10000, 3'd3, rnd64(), rnd64(), rnd64(),
			rnd64());
		random_items(150, 32'hFFFFFFFF);
		// hold off until everything is back, then carry on
		in_if.valid <= 1'b0;
		drain();
		random_items(200, 32'hFFFFFFFF);

		// round count beyond the maximum saturates
		configure(32'd990000, 17'd1000, 17'd999, 3'd7, rnd64(), rnd64(), rnd64(), rnd64());
		send_item(1'b0, 32'd989999);
		send_item(1'b1, 32'd990000);
		random_items(280, 32'd990000);

		configure(32'd2000, 17'd300, 17'd7, 3'd1, '1, rnd64(), rnd64(), rnd64());
		random_items(200, 32'd2000);

		// domain above the radix product: first step leaves its block
		configure(32'd1000, 17'd10, 17'd10, 3'd2, rnd64(), rnd64(), rnd64(), rnd64());
		send_item(1'b0, 32'd999);
		send_item(1'b1, 32'd999);
		random_items(20, 32'd1000);

		configure(32'd131071, 17'h1FFFF, 17'd1, 3'd2, rnd64(), rnd64(), rnd64(), rnd64());
		random_items(60, 32'd131071);

		in_if.valid <= 1'b0;
		drain();
		repeat (600) @(posedge clk);
		$display("Covered %0d items (%0d out of range), %0d results, over nine settings",
			sb.n_in, sb.n_oor, sb.n_out);
		$display("with both directions, zero and saturated round counts and random stalls.");
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
